### design/assert_macros.svh
// Assertion macros used by stpg_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMPL(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CHK_IMPL(lbl, clk, rst_n, prop, msg)
`define CHK_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

### design/stpg_pkg.sv
`timescale 1ns / 1ps
package stpg_pkg;
    localparam int PHASE_FRACTION_BITS = 24;
    localparam int CORDIC_ITERATIONS = 16;
    localparam logic [15:0] LEN_RESET = 16'd10000;
    localparam logic [15:0] RAD_RESET = 16'd5000;
    localparam logic [15:0] SPD_RESET = 16'd1500;
    localparam logic [1:0] CFG_LEN = 2'd0;
    localparam logic [1:0] CFG_RAD = 2'd1;
    localparam logic [1:0] CFG_SPD = 2'd2;
    localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
    localparam logic [17:0] PI_Q16 = 18'd205887;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic [15:0] HEAD_BACK = 16'd32768;

    typedef struct packed {
        logic       load;
        logic       mul2;
        logic       div_init;
        logic       div_step;
        logic       div_first;
        logic       upd;
        logic       pos_init;
        logic       rot;
        logic       mulo;
        logic       fin;
        logic [5:0] idx;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
    } t_sts;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
            5'd20: v = 32'd652;       5'd21: v = 32'd326;
            5'd22: v = 32'd163;       5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction
endpackage

### design/stpg_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stpg_ctrl #(
    parameter int PF = stpg_pkg::PHASE_FRACTION_BITS,
    parameter int CI = stpg_pkg::CORDIC_ITERATIONS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic           i_out_ready,
    input  stpg_pkg::t_sts i_sts,
    output stpg_pkg::t_cmd o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL  = 4'd1;
    localparam logic [3:0] S_CMP  = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_UPD  = 4'd4;
    localparam logic [3:0] S_POS  = 4'd5;
    localparam logic [3:0] S_ROT  = 4'd6;
    localparam logic [3:0] S_MULO = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [3:0] r_state, n_state;
    logic [5:0] r_cnt, n_cnt;

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        o_cmd = '0;
        o_cmd.idx = r_cnt;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul2 = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.div_init = 1'b1;
                n_cnt = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                o_cmd.div_first = (r_cnt == 6'd0);
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(PF)) n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state = S_POS;
            end
            S_POS: begin
                o_cmd.pos_init = 1'b1;
                n_cnt = '0;
                n_state = S_ROT;
            end
            S_ROT: begin
                o_cmd.rot = 1'b1;
                n_cnt = r_cnt + 6'd1;
                if (r_cnt == 6'(CI - 1)) n_state = S_MULO;
            end
            S_MULO: begin
                o_cmd.mulo = 1'b1;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!i_sts.out_valid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_cnt <= n_cnt;
        end
    end

    `CHK_IMPL(a_fin_free, i_clk, i_rst_n, o_cmd.fin |-> (!i_sts.out_valid || i_out_ready), "fin over busy output")
    `CHK_NEXT(a_busy_after, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `CHK_IMPL(a_one_cmd, i_clk, i_rst_n, $onehot0({o_cmd.load, o_cmd.mul2, o_cmd.div_init, o_cmd.div_step, o_cmd.upd, o_cmd.pos_init, o_cmd.rot, o_cmd.mulo, o_cmd.fin}), "overlapping commands")
endmodule

### design/stpg_dp.sv
`timescale 1ns / 1ps
module stpg_dp #(
    parameter int PF = stpg_pkg::PHASE_FRACTION_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic [19:0]        i_time_step_us,
    input  stpg_pkg::t_cmd     i_cmd,
    output stpg_pkg::t_sts     o_sts,
    input  logic               i_out_ready,
    output logic signed [17:0] o_pos_x_mm,
    output logic signed [17:0] o_pos_y_mm,
    output logic [15:0]        o_heading_angle,
    output logic [1:0]         o_segment_index
);
    localparam int PW = PF + 1;
    localparam logic [PW-1:0] PH_MAX = {PW{1'b1}};
    localparam logic [PW-1:0] PH_ONE = PW'(1) << PF;
    localparam logic [PW-1:0] PH_HALF = PW'(1) << (PF - 1);

    logic [15:0] r_len, r_rad, r_spd;
    logic [1:0] r_seg;
    logic [PW-1:0] r_phase;
    logic [55:0] r_num, r_den, r_rem;
    logic [PW-1:0] r_q;
    logic r_sat;
    logic [31:0] r_ang;
    logic r_flip;
    logic signed [33:0] r_cx, r_cy;
    logic signed [32:0] r_cz;
    logic [PF+17:0] r_along;
    logic signed [50:0] r_ps, r_pc;
    logic r_out_valid;
    logic signed [17:0] r_x, r_y;
    logic [15:0] r_head;
    logic [1:0] r_oseg;

    logic arc;
    logic [15:0] base;
    logic [56:0] rr, rs;
    logic bitq;
    logic [PW:0] sum;
    logic [PF+31:0] ang_ext;
    logic [31:0] ang_n, a_rot;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;
    logic [17:0] along;
    logic signed [20:0] rsn, rcs;

    assign arc = r_seg[0];
    assign base = arc ? r_rad : r_len;
    assign o_sts.out_valid = r_out_valid;

    always_comb begin
        rr = i_cmd.div_first ? {1'b0, r_rem} : {r_rem, 1'b0};
        rs = rr - {1'b0, r_den};
        bitq = (rr >= {1'b0, r_den});
        sum = {1'b0, r_phase} + {1'b0, r_sat ? PH_MAX : r_q};
        ang_ext = {r_phase, 31'b0};
        ang_n = ang_ext[PF+31:PF] + (r_seg[1] ? 32'h80000000 : 32'h0);
        a_rot = ang_n + 32'h40000000;
        dx = r_cy >>> i_cmd.idx[4:0];
        dy = r_cx >>> i_cmd.idx[4:0];
        at = $signed({1'b0, stpg_pkg::atan_val(i_cmd.idx[4:0])});
        along = r_along[PF+17:PF];
        rsn = 21'(((r_flip ? -r_ps : r_ps) + 51'sd536870912) >>> 30);
        rcs = 21'(((r_flip ? -r_pc : r_pc) + 51'sd536870912) >>> 30);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= stpg_pkg::LEN_RESET;
            r_rad <= stpg_pkg::RAD_RESET;
            r_spd <= stpg_pkg::SPD_RESET;
            r_seg <= 2'd0;
            r_phase <= PH_HALF;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    stpg_pkg::CFG_LEN: r_len <= i_cfg_data;
                    stpg_pkg::CFG_RAD: r_rad <= i_cfg_data;
                    stpg_pkg::CFG_SPD: r_spd <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.upd) r_phase <= sum[PW] ? PH_MAX : sum[PW-1:0];
            if (i_cmd.fin) begin
                r_out_valid <= 1'b1;
                if (r_phase >= PH_ONE) begin
                    r_phase <= '0;
                    r_seg <= r_seg + 2'd1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num <= 56'(i_time_step_us * r_spd);
            r_den <= 56'((base == 16'd0 ? 16'd1 : base) * stpg_pkg::USEC_PER_SEC);
        end
        if (i_cmd.mul2 && arc) begin
            r_num <= r_num << 16;
            r_den <= 56'(r_den[35:0] * stpg_pkg::PI_Q16);
        end
        if (i_cmd.div_init) begin
            r_sat <= ({1'b0, r_num} >= {r_den, 1'b0});
            r_rem <= r_num;
            r_q <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= bitq ? rs[55:0] : rr[55:0];
            r_q <= {r_q[PW-2:0], bitq};
        end
        if (i_cmd.pos_init) begin
            r_ang <= ang_n;
            r_flip <= a_rot[31];
            r_cz <= $signed({ang_n[31] ^ a_rot[31], ang_n[31] ^ a_rot[31],
                             ang_n[30:0]});
            r_cx <= stpg_pkg::CORDIC_GAIN;
            r_cy <= '0;
            r_along <= (PF+18)'(r_phase * r_len) + (PF+18)'(PH_HALF);
        end
        if (i_cmd.rot) begin
            if (!r_cz[32]) begin
                r_cx <= r_cx - dx;
                r_cy <= r_cy + dy;
                r_cz <= r_cz - at;
            end else begin
                r_cx <= r_cx + dx;
                r_cy <= r_cy - dy;
                r_cz <= r_cz + at;
            end
        end
        if (i_cmd.mulo) begin
            r_ps <= r_cy * $signed({1'b0, r_rad});
            r_pc <= r_cx * $signed({1'b0, r_rad});
        end
        if (i_cmd.fin) begin
            r_oseg <= r_seg;
            case (r_seg)
                2'd0: begin
                    r_x <= $signed(along);
                    r_y <= -$signed({2'b0, r_rad});
                    r_head <= 16'd0;
                end
                2'd2: begin
                    r_x <= $signed({2'b0, r_len} - along);
                    r_y <= $signed({2'b0, r_rad});
                    r_head <= stpg_pkg::HEAD_BACK;
                end
                default: begin
                    r_x <= $signed(rsn[17:0] + (r_seg == 2'd1 ? {2'b0, r_len} : 18'd0));
                    r_y <= -rcs[17:0];
                    r_head <= r_ang[31:16];
                end
            endcase
        end
    end

    assign o_pos_x_mm = r_x;
    assign o_pos_y_mm = r_y;
    assign o_heading_angle = r_head;
    assign o_segment_index = r_oseg;
endmodule

### design/stadium_track_path_generator_top.sv
`timescale 1ns / 1ps
// Stadium track path generator.
// Input channel: i_in_valid / o_in_ready carry one time step (microseconds).
// Output channel: o_out_valid / i_out_ready carry position, heading and the
// segment used for that step, one result per input transaction.
// Configuration: i_cfg_we writes length (0), radius (1) or speed (2) at once.
// Steps from accept to result: load, scale multiply, compare, phase division,
// phase update, CORDIC set-up, CORDIC rotation, output multiply and result
// register. One transaction is in work at a time; the next input can be
// taken in the cycle after the result is registered. The phase divider
// produces one quotient bit per cycle and the CORDIC rotator is iterative.
// Reset restores the default registers, segment zero and phase one half.
// When the receiver stalls, the result holds in the output register; a new
// input may still be accepted and computed, and it waits to be registered
// until the held result is taken.
module stadium_track_path_generator_top #(
    parameter int PHASE_FRACTION_BITS = stpg_pkg::PHASE_FRACTION_BITS,
    parameter int CORDIC_ITERATIONS = stpg_pkg::CORDIC_ITERATIONS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [19:0]        i_time_step_us,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [17:0] o_pos_x_mm,
    output logic signed [17:0] o_pos_y_mm,
    output logic [15:0]        o_heading_angle,
    output logic [1:0]         o_segment_index
);
    stpg_pkg::t_cmd cmd;
    stpg_pkg::t_sts sts;

    stpg_ctrl #(.PF(PHASE_FRACTION_BITS), .CI(CORDIC_ITERATIONS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_out_ready(i_out_ready),
        .i_sts(sts), .o_cmd(cmd)
    );

    stpg_dp #(.PF(PHASE_FRACTION_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_time_step_us(i_time_step_us), .i_cmd(cmd), .o_sts(sts),
        .i_out_ready(i_out_ready), .o_pos_x_mm(o_pos_x_mm),
        .o_pos_y_mm(o_pos_y_mm), .o_heading_angle(o_heading_angle),
        .o_segment_index(o_segment_index)
    );

    assign o_out_valid = sts.out_valid;
endmodule

### test/tb_stadium_track_path_generator_top.sv
`timescale 1ns / 1ps
module tb_stadium_track_path_generator_top;
    localparam int FB = stpg_pkg::PHASE_FRACTION_BITS;
    localparam logic [FB:0] PH_ONE = {1'b1, {FB{1'b0}}};
    localparam logic [FB:0] PH_MAX = {(FB + 1){1'b1}};

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic [15:0]        hdg;
        logic [1:0]         seg;
    } t_pose;

    class track_scoreboard;
        logic [15:0] len_mm, rad_mm, spd;
        logic [1:0]  seg;
        logic [FB:0] phase;
        t_pose       pending_poses[$];
        int          n_err, n_in, n_out;
        int          seg_seen[4];

        function new();
            len_mm = stpg_pkg::LEN_RESET;
            rad_mm = stpg_pkg::RAD_RESET;
            spd = stpg_pkg::SPD_RESET;
            seg = 2'd0;
            phase = PH_ONE >> 1;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] v);
            if (idx == stpg_pkg::CFG_LEN) len_mm = v;
            else if (idx == stpg_pkg::CFG_RAD) rad_mm = v;
            else if (idx == stpg_pkg::CFG_SPD) spd = v;
        endfunction

        function logic [FB:0] phase_step(logic [127:0] num, logic [127:0] den);
            logic [127:0] q;
            q = (num << FB) / den;
            return (q > 128'(PH_MAX)) ? PH_MAX : q[FB:0];
        endfunction

        function void sin_cos(logic [31:0] ang, output longint sn, output longint cs);
            logic        flip;
            logic [31:0] a;
            longint      x, y, z, dx, dy;
            flip = ang[31] ^ ang[30];
            a = flip ? ang - 32'h8000_0000 : ang;
            z = longint'($signed(a));
            x = longint'(stpg_pkg::CORDIC_GAIN);
            y = 0;
            for (int i = 0; i < stpg_pkg::CORDIC_ITERATIONS && i < 24; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0) begin
                    x -= dx; y += dy; z -= longint'(stpg_pkg::atan_val(5'(i)));
                end else begin
                    x += dx; y -= dy; z += longint'(stpg_pkg::atan_val(5'(i)));
                end
            end
            sn = flip ? -y : y;
            cs = flip ? -x : x;
        endfunction

        function void note_input(logic [19:0] dt);
            logic [127:0] lden, rden;
            logic [FB:0]  inc;
            logic [FB+1:0] sum;
            logic [63:0]  along;
            logic [31:0]  ang;
            longint       sn, cs;
            t_pose        p;
            lden = (len_mm == 16'd0) ? 128'd1 : 128'(len_mm);
            rden = (rad_mm == 16'd0) ? 128'd1 : 128'(rad_mm);
            if (!seg[0])
                inc = phase_step(128'(dt) * spd, lden * 1000000);
            else
                inc = phase_step(128'(dt) * spd * 65536, rden * 1000000 * 205887);
            sum = {1'b0, phase} + {1'b0, inc};
            phase = (sum > {1'b0, PH_MAX}) ? PH_MAX : sum[FB:0];
            p.seg = seg;
            if (!seg[0]) begin
                along = (64'(phase) * len_mm + (64'(PH_ONE) >> 1)) >> FB;
                if (seg == 2'd0) begin
                    p.x = along[17:0];
                    p.y = -$signed({2'b0, rad_mm});
                    p.hdg = 16'd0;
                end else begin
                    p.x = 18'(longint'(len_mm) - longint'(along));
                    p.y = {2'b0, rad_mm};
                    p.hdg = stpg_pkg::HEAD_BACK;
                end
            end else begin
                ang = 32'(64'(phase) << (31 - FB));
                if (seg == 2'd3) ang += 32'h8000_0000;
                sin_cos(ang, sn, cs);
                p.x = 18'(((sn * longint'(rad_mm) + (64'sd1 <<< 29)) >>> 30)
                          + (seg == 2'd1 ? longint'(len_mm) : 64'sd0));
                p.y = 18'(-((cs * longint'(rad_mm) + (64'sd1 <<< 29)) >>> 30));
                p.hdg = ang[31:16];
            end
            pending_poses.push_back(p);
            seg_seen[seg]++;
            n_in++;
            if (phase >= PH_ONE) begin
                phase = '0;
                seg = seg + 2'd1;
            end
        endfunction

        function void check(t_pose got);
            t_pose e;
            n_out++;
            if (pending_poses.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result x=%0d y=%0d", got.x, got.y);
                return;
            end
            e = pending_poses.pop_front();
            if (e.x !== got.x || e.y !== got.y || e.hdg !== got.hdg || e.seg !== got.seg) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch #%0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                             n_out, e.x, e.y, e.hdg, e.seg, got.x, got.y, got.hdg, got.seg);
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = stpg_pkg::CFG_LEN;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [19:0]        i_time_step_us = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [17:0] o_pos_x_mm;
    logic signed [17:0] o_pos_y_mm;
    logic [15:0]        o_heading_angle;
    logic [1:0]         o_segment_index;

    track_scoreboard sb = new();
    bit hold_off_req = 1'b0;
    bit no_idle = 1'b0;

    stadium_track_path_generator_top uut (.*);

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        t_pose r;
        if (i_rst_n && i_in_valid && o_in_ready) sb.note_input(i_time_step_us);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            r.x = o_pos_x_mm;
            r.y = o_pos_y_mm;
            r.hdg = o_heading_angle;
            r.seg = o_segment_index;
            sb.check(r);
        end
    end

    function int gap_len();
        if (no_idle || $urandom_range(0, 9) < 6) return 0;
        return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 120) : $urandom_range(1, 4);
    endfunction

    initial begin
        int g;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                i_out_ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_off_req = 1'b0;
            end
            g = gap_len();
            if (g > 0) begin
                i_out_ready = 1'b0;
                repeat (g - 1) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [15:0] v);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = v;
        sb.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic send_step(logic [19:0] dt);
        int g;
        i_in_valid = 1'b1;
        i_time_step_us = dt;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            i_in_valid = 1'b0;
            i_time_step_us = 20'($urandom);
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending_poses.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    function logic [19:0] rand_step();
        case ($urandom_range(0, 9))
            0: return 20'd0;
            1: return 20'hFFFFF;
            2, 3: return 20'($urandom);
            4, 5: return 20'($urandom_range(0, 200000));
            default: return 20'($urandom_range(0, 5000));
        endcase
    endfunction

    function logic [15:0] rand_reg(bit allow_zero);
        case ($urandom_range(0, 5))
            0: return allow_zero ? 16'd0 : 16'd1;
            1: return 16'hFFFF;
            2: return 16'($urandom);
            default: return 16'($urandom_range(500, 20000));
        endcase
    endfunction

    initial begin
        logic [19:0] dir_steps[10] = '{20'd0, 20'hFFFFF, 20'd1, 20'hFFFFF, 20'd333333,
                                       20'hFFFFF, 20'd7, 20'hFFFFF, 20'hAAAAA, 20'h55555};
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_steps[k]) send_step(dir_steps[k]);
        drain();
        write_reg(stpg_pkg::CFG_LEN, 16'd0);
        write_reg(stpg_pkg::CFG_RAD, 16'd0);
        write_reg(stpg_pkg::CFG_SPD, 16'hFFFF);
        repeat (6) send_step(20'hFFFFF);
        drain();
        write_reg(stpg_pkg::CFG_LEN, 16'hFFFF);
        write_reg(stpg_pkg::CFG_RAD, 16'hFFFF);
        write_reg(stpg_pkg::CFG_SPD, 16'd0);
        repeat (3) send_step(20'hFFFFF);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            write_reg(stpg_pkg::CFG_LEN, rand_reg(1'b1));
            write_reg(stpg_pkg::CFG_RAD, rand_reg(1'b1));
            write_reg(stpg_pkg::CFG_SPD, (ph == 0) ? 16'hFFFF : rand_reg(1'b1));
            no_idle = (ph == 2);
            if (ph == 4) hold_off_req = 1'b1;
            repeat (60) send_step(rand_step());
            drain();
        end
        no_idle = 1'b0;

        $display("covered %0d steps; per segment %0d/%0d/%0d/%0d",
                 sb.n_in, sb.seg_seen[0], sb.seg_seen[1], sb.seg_seen[2], sb.seg_seen[3]);
        $display("register extremes, saturating steps and a long output stall included");
        if (sb.n_err == 0) begin
            $display("PASS stadium_track_path_generator_top");
        end else begin
            $display("%0d mismatches", sb.n_err);
            $display("FAIL stadium_track_path_generator_top");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("FAIL stadium_track_path_generator_top");
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/stpg_pkg.sv
design/stpg_ctrl.sv
design/stpg_dp.sv
design/stadium_track_path_generator_top.sv
test/tb_stadium_track_path_generator_top.sv
